### rtl/core/aarm_pkg.sv
package aarm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANG_TABLE_LEN = 24;
  localparam int NUM_CELLS = (CORDIC_STEPS > ANG_TABLE_LEN) ? ANG_TABLE_LEN : CORDIC_STEPS;

  localparam int ZW = 34;   // Q.30 working width for x, y, z
  localparam int SUMW = 52; // Q.42 accumulation width

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [ZW-1:0] GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic                 valid;
    logic                 flip;
    logic signed [ZW-1:0] x;
    logic signed [ZW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [15:0]   ax;
    logic signed [15:0]   ay;
    logic signed [15:0]   az;
  } cordic_bus_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 34'sh3243F6A8;
      5'd1:  r = 34'sh1DAC6705;
      5'd2:  r = 34'sh0FADBAFC;
      5'd3:  r = 34'sh07F56EA6;
      5'd4:  r = 34'sh03FEAB76;
      5'd5:  r = 34'sh01FFD55B;
      5'd6:  r = 34'sh00FFFAAA;
      5'd7:  r = 34'sh007FFF55;
      5'd8:  r = 34'sh003FFFEA;
      5'd9:  r = 34'sh001FFFFD;
      5'd10: r = 34'sh000FFFFF;
      5'd11: r = 34'sh0007FFFF;
      5'd12: r = 34'sh0003FFFF;
      5'd13: r = 34'sh0001FFFF;
      5'd14: r = 34'sh0000FFFF;
      5'd15: r = 34'sh00007FFF;
      5'd16: r = 34'sh00003FFF;
      5'd17: r = 34'sh00001FFF;
      5'd18: r = 34'sh00000FFF;
      5'd19: r = 34'sh000007FF;
      5'd20: r = 34'sh000003FF;
      5'd21: r = 34'sh000001FF;
      5'd22: r = 34'sh000000FF;
      5'd23: r = 34'sh0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q.42 -> Q1.14 with round half up and saturation
  function automatic logic signed [15:0] round_sat(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] b;
    logic signed [SUMW-29:0] r;
    b = v + SUMW'(64'sd134217728);
    r = b[SUMW-1:28];
    if (r > 24'sd32767) return 16'sd32767;
    if (r < -24'sd32768) return -16'sd32768;
    return r[15:0];
  endfunction

endpackage

### rtl/core/aarm_cordic_cell.sv
module aarm_cordic_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [4:0]           idx,
  input  aarm_pkg::cordic_bus_t din,
  output aarm_pkg::cordic_bus_t dout
);
  import aarm_pkg::*;

  logic signed [ZW-1:0] dx, dy, ang;
  cordic_bus_t step_next;

  always_comb begin
    dx = din.y >>> idx;
    dy = din.x >>> idx;
    ang = atan_q30(idx);
    step_next = din;
    if (!din.z[ZW-1]) begin
      step_next.x = din.x - dx;
      step_next.y = din.y + dy;
      step_next.z = din.z - ang;
    end else begin
      step_next.x = din.x + dx;
      step_next.y = din.y - dy;
      step_next.z = din.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.flip <= step_next.flip;
      dout.x <= step_next.x;
      dout.y <= step_next.y;
      dout.z <= step_next.z;
      dout.ax <= step_next.ax;
      dout.ay <= step_next.ay;
      dout.az <= step_next.az;
    end
  end

endmodule

### rtl/core/aarm_matrix.sv
module aarm_matrix (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  aarm_pkg::cordic_bus_t din,
  output logic                  out_valid,
  output logic signed [15:0]    m00,
  output logic signed [15:0]    m01,
  output logic signed [15:0]    m02,
  output logic signed [15:0]    m10,
  output logic signed [15:0]    m11,
  output logic signed [15:0]    m12,
  output logic signed [15:0]    m20,
  output logic signed [15:0]    m21,
  output logic signed [15:0]    m22
);
  import aarm_pkg::*;

  // stage a: rounded c, s, t and first products
  logic signed [ZW-1:0] xf, yf, xr, yr;
  logic signed [17:0] c_next, s_next;
  logic va, vb;
  logic signed [17:0] ca, ta;
  logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [33:0] sxa, sya, sza;
  // stage b
  logic signed [49:0] txx, tyy, tzz, txy, txz, tyz;
  logic signed [SUMW-1:0] cb, sxb, syb, szb;

  always_comb begin
    xf = din.flip ? -din.x : din.x;
    yf = din.flip ? -din.y : din.y;
    xr = xf + ZW'(32768);
    yr = yf + ZW'(32768);
    c_next = xr[ZW-1:16];
    s_next = yr[ZW-1:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= din.valid;
      vb <= va;
      out_valid <= vb;
    end
    if (en) begin
      ca <= c_next;
      ta <= 18'sd16384 - c_next;
      pxx <= din.ax * din.ax;
      pyy <= din.ay * din.ay;
      pzz <= din.az * din.az;
      pxy <= din.ax * din.ay;
      pxz <= din.ax * din.az;
      pyz <= din.ay * din.az;
      sxa <= s_next * din.ax;
      sya <= s_next * din.ay;
      sza <= s_next * din.az;

      txx <= ta * pxx;
      tyy <= ta * pyy;
      tzz <= ta * pzz;
      txy <= ta * pxy;
      txz <= ta * pxz;
      tyz <= ta * pyz;
      cb <= SUMW'(ca) <<< 28;
      sxb <= SUMW'(sxa) <<< 14;
      syb <= SUMW'(sya) <<< 14;
      szb <= SUMW'(sza) <<< 14;

      m00 <= round_sat(SUMW'(txx) + cb);
      m01 <= round_sat(SUMW'(txy) - szb);
      m02 <= round_sat(SUMW'(txz) + syb);
      m10 <= round_sat(SUMW'(txy) + szb);
      m11 <= round_sat(SUMW'(tyy) + cb);
      m12 <= round_sat(SUMW'(tyz) - sxb);
      m20 <= round_sat(SUMW'(txz) - syb);
      m21 <= round_sat(SUMW'(tyz) + sxb);
      m22 <= round_sat(SUMW'(tzz) + cb);
    end
  end

endmodule

### rtl/core/axis_angle_to_rotation_matrix.sv
// Axis-angle to rotation matrix (Rodrigues form R = c*I + s*[a]x + t*a*a^T).
// Input channel: in_valid/in_ready carry axis_x, axis_y, axis_z (Q1.14) and
// turn_angle (Q3.13). Output channel: out_valid/out_ready carry the nine
// entries m00..m22, row-major, Q1.14, saturated.
// One result per input transfer, in order.
// Pipeline: one register of half-turn reduction, one CORDIC cell per step,
// two multiply stages and the output register.
// Throughput: one transfer per cycle while the receiver takes results. The
// whole pipeline moves on a single enable; it advances whenever the output
// register is empty or is being taken, so a stalled receiver holds every
// stage and deasserts in_ready until the result is taken.
// Reset (rst, synchronous) clears all stage valid bits; no results pending.
module axis_angle_to_rotation_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [15:0] turn_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22
);
  import aarm_pkg::*;

  logic en;
  logic signed [ZW-1:0] z_wide;
  cordic_bus_t red_next;
  cordic_bus_t chain [0:NUM_CELLS];

  assign en = out_ready || !out_valid;
  assign in_ready = en;

  // half-turn reduction keeps the CORDIC argument within pi/2
  always_comb begin
    z_wide = ZW'(turn_angle) <<< 17;
    red_next.valid = in_valid;
    red_next.x = GAIN_Q30;
    red_next.y = '0;
    red_next.ax = axis_x;
    red_next.ay = axis_y;
    red_next.az = axis_z;
    if (z_wide > HALF_PI_Q30) begin
      red_next.z = z_wide - PI_Q30;
      red_next.flip = 1'b1;
    end else if (z_wide < -HALF_PI_Q30) begin
      red_next.z = z_wide + PI_Q30;
      red_next.flip = 1'b1;
    end else begin
      red_next.z = z_wide;
      red_next.flip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0].valid <= red_next.valid;
    end
    if (en) begin
      chain[0].flip <= red_next.flip;
      chain[0].x <= red_next.x;
      chain[0].y <= red_next.y;
      chain[0].z <= red_next.z;
      chain[0].ax <= red_next.ax;
      chain[0].ay <= red_next.ay;
      chain[0].az <= red_next.az;
    end
  end

  // one CORDIC step per cell
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    aarm_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .idx  (5'(i)),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  aarm_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .din       (chain[NUM_CELLS]),
    .out_valid (out_valid),
    .m00       (m00),
    .m01       (m01),
    .m02       (m02),
    .m10       (m10),
    .m11       (m11),
    .m12       (m12),
    .m20       (m20),
    .m21       (m21),
    .m22       (m22)
  );

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> chain[0].valid)
    else $error("accepted input did not enter the pipeline");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !chain[0].valid))
    else $error("valid bits not cleared by reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(chain[NUM_CELLS]))
    else $error("pipeline moved while output stalled");
`endif

endmodule
